// ===== design/voxel_distance_propagation_top_defines.svh =====
// ---------------------------------------------------------------------------
// Voxel distance propagation assertion macros
// Shared property shapes for the top level checks.
// ---------------------------------------------------------------------------
`ifndef VOXEL_DISTANCE_PROPAGATION_TOP_DEFINES_SVH
`define VOXEL_DISTANCE_PROPAGATION_TOP_DEFINES_SVH

// same-cycle implication
`define VDP_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);

// next-cycle implication
`define VDP_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);

`endif

// ===== design/vdp_pkg.sv =====
// ---------------------------------------------------------------------------
// vdp_pkg
// Types, sizes and codes shared by the distance propagation modules.
// ---------------------------------------------------------------------------
package vdp_pkg;

	localparam int CELLS_PER_AXIS = 32;
	localparam int AXIS_W         = 5;
	localparam int CELL_W         = 3 * AXIS_W;
	localparam int GRID_CELLS     = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
	localparam int QUEUE_ENTRIES  = 4096;
	localparam int QPTR_W         = 12;
	localparam int POOL_W         = QPTR_W + 1;
	localparam int MAX_DIST_LIMIT = 31;
	localparam int BUCKETS        = MAX_DIST_LIMIT * MAX_DIST_LIMIT + 1;
	localparam int BKT_W          = 10;
	localparam int DIST_W         = 10;
	localparam int DSUM_W         = 12;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_PROP  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_CLEAR = 2'd3
	} act_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CLR, S_ADD, S_PUSH, S_PUSHW, S_QRD, S_OUT,
		S_BRD, S_BCHK, S_CRD, S_NLAT, S_NB, S_NCMP, S_CEND, S_QNLAT, S_BNEXT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SWEEP, OP_ADD, OP_PUSH_RD, OP_PUSH_WR, OP_QRD, OP_OUT,
		OP_BRD, OP_BCHK, OP_CRD, OP_NLAT, OP_NB, OP_NCMP, OP_CEND, OP_QNLAT, OP_BNEXT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   in_prop;
	} dp_cmd_t;

	typedef struct packed {
		logic sw_last;
		logic blive;
		logic nb_end;
		logic nb_ok;
		logic better;
		logic want_push;
		logic cell_last;
		logic b_last;
		logic pool_full;
		logic push_cur;
	} dp_sts_t;

	typedef struct packed {
		logic              live;
		logic [QPTR_W-1:0] head;
		logic [QPTR_W-1:0] tail;
	} bkt_t;

endpackage

// ===== design/voxel_distance_propagation_top.sv =====
// ---------------------------------------------------------------------------
// voxel_distance_propagation_top
// 3D brushfire distance transform over a 32^3 grid with a bucket queue.
// ---------------------------------------------------------------------------
//  channel  | handshake           | word
//  command  | start / busy        | action, cell_x, cell_y, cell_z
//  result   | done (one cycle)    | distance_sq, nearest_x/y/z, status
//  config   | cfg_we              | cfg_wdata (max_distance_cells)
//
//  After reset the field memory is swept with busy high.
//  Clear sweeps the field again, one cell per cycle.
//  Propagate visits every bucket up to max^2 and, for each dequeued
//  cell, does a one neighbour at a time read-modify-write on the field
//  memory and pushes improved neighbours onto the queue.
//  The result strobe cannot be held off; busy falls in the cycle it is shown.
// ---------------------------------------------------------------------------
`include "voxel_distance_propagation_top_defines.svh"

module voxel_distance_propagation_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_x,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_y,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_z,
	input  logic                        cfg_we,
	input  logic [vdp_pkg::AXIS_W-1:0]  cfg_wdata,
	output logic                        done,
	output logic [vdp_pkg::DIST_W-1:0]  distance_sq,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_x,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_y,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_z,
	output logic                        status
);
	import vdp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	vdp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	vdp_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.action      (action),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_z      (cell_z),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.distance_sq (distance_sq),
		.nearest_x   (nearest_x),
		.nearest_y   (nearest_y),
		.nearest_z   (nearest_z),
		.status      (status)
	);

	`VDP_ASSERT_NEXT(a_done_single, done, !done, "result strobe held two cycles")
	`VDP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`VDP_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without work in flight")

endmodule

// ===== design/vdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// vdp_ctrl
// Sequencer for add, propagate, query and clear, driving the datapath.
// ---------------------------------------------------------------------------
module vdp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       action,
	input  vdp_pkg::dp_sts_t sts,
	output vdp_pkg::dp_cmd_t cmd,
	output logic             busy
);
	import vdp_pkg::*;

	ctrl_state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ret_q   <= S_OUT;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cmd.op      = OP_NONE;
		cmd.in_prop = (ret_q == S_NB);
		busy        = (state_q != S_IDLE);
		case (state_q)
			S_INIT: begin
				cmd.op = OP_SWEEP;
				if (sts.sw_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_LOAD;
					case (act_t'(action))
						ACT_ADD:   state_d = S_ADD;
						ACT_PROP:  state_d = S_BRD;
						ACT_QUERY: state_d = S_QRD;
						ACT_CLEAR: state_d = S_CLR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				cmd.op = OP_SWEEP;
				if (sts.sw_last) state_d = S_OUT;
			end
			S_ADD: begin
				cmd.op  = OP_ADD;
				ret_d   = S_OUT;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.op = OP_PUSH_RD;
				if (sts.pool_full || sts.push_cur) state_d = ret_q;
				else state_d = S_PUSHW;
			end
			S_PUSHW: begin
				cmd.op  = OP_PUSH_WR;
				state_d = ret_q;
			end
			S_QRD: begin
				cmd.op  = OP_QRD;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.op  = OP_OUT;
				state_d = S_IDLE;
			end
			S_BRD: begin
				cmd.op  = OP_BRD;
				state_d = S_BCHK;
			end
			S_BCHK: begin
				cmd.op  = OP_BCHK;
				state_d = sts.blive ? S_CRD : S_BNEXT;
			end
			S_CRD: begin
				cmd.op  = OP_CRD;
				state_d = S_NLAT;
			end
			S_NLAT: begin
				cmd.op  = OP_NLAT;
				state_d = S_NB;
			end
			S_NB: begin
				cmd.op = OP_NB;
				if (sts.nb_end) state_d = S_CEND;
				else if (sts.nb_ok) state_d = S_NCMP;
			end
			S_NCMP: begin
				cmd.op = OP_NCMP;
				if (sts.better && sts.want_push) begin
					ret_d   = S_NB;
					state_d = S_PUSH;
				end else begin
					state_d = S_NB;
				end
			end
			S_CEND: begin
				cmd.op  = OP_CEND;
				state_d = sts.cell_last ? S_BNEXT : S_QNLAT;
			end
			S_QNLAT: begin
				cmd.op  = OP_QNLAT;
				state_d = S_CRD;
			end
			S_BNEXT: begin
				cmd.op  = OP_BNEXT;
				state_d = sts.b_last ? S_OUT : S_BRD;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/vdp_dpath.sv =====
// ---------------------------------------------------------------------------
// vdp_dpath
// Cell field, bucket queue memories, neighbour arithmetic and result word.
// ---------------------------------------------------------------------------
module vdp_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vdp_pkg::dp_cmd_t            cmd,
	output vdp_pkg::dp_sts_t            sts,
	input  logic [1:0]                  action,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_x,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_y,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_z,
	input  logic                        cfg_we,
	input  logic [vdp_pkg::AXIS_W-1:0]  cfg_wdata,
	output logic                        done,
	output logic [vdp_pkg::DIST_W-1:0]  distance_sq,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_x,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_y,
	output logic [vdp_pkg::AXIS_W-1:0]  nearest_z,
	output logic                        status
);
	import vdp_pkg::*;

	// memories
	logic [DIST_W-1:0] dist_mem [GRID_CELLS];
	logic [CELL_W-1:0] near_mem [GRID_CELLS];
	logic [CELL_W-1:0] qent_mem [QUEUE_ENTRIES];
	logic [QPTR_W-1:0] qnext_mem [QUEUE_ENTRIES];
	bkt_t              bkt_mem [BUCKETS];

	logic              dist_we, dist_re, near_we, near_re;
	logic [CELL_W-1:0] dist_wa, dist_ra, near_wa, near_ra;
	logic [DIST_W-1:0] dist_wd, dist_rd;
	logic [CELL_W-1:0] near_wd, near_rd;
	logic              qent_we, qent_re, qnext_we, qnext_re, bkt_we, bkt_re;
	logic [QPTR_W-1:0] qent_wa, qent_ra, qnext_wa, qnext_ra, qnext_wd, qnext_rd;
	logic [CELL_W-1:0] qent_wd, qent_rd;
	logic [BKT_W-1:0]  bkt_wa, bkt_ra;
	bkt_t              bkt_wd, bkt_rd;

	// control registers
	logic [AXIS_W-1:0] max_q;
	logic [CELL_W-1:0] sw_q;
	logic [POOL_W-1:0] pool_q;
	logic              ovf_q, done_q;

	// payload registers
	logic [1:0]        act_q;
	logic [CELL_W-1:0] in_cell_q, cel_q, np_q, n_q, pc_q;
	logic [BKT_W-1:0]  b_q, pb_q;
	logic [QPTR_W-1:0] cur_q, bt_q;
	logic [1:0]        ox_q, oy_q, oz_q;
	logic [DSUM_W-1:0] d_q;
	logic [DIST_W-1:0] dist_out_q;
	logic [CELL_W-1:0] near_out_q;

	logic [DIST_W-1:0] max_sq;
	logic [6:0]        nxw, nyw, nzw, nx, ny, nz;
	logic signed [6:0] ex, ey, ez;
	logic signed [13:0] sqx, sqy, sqz;
	logic [DSUM_W-1:0] dsum;
	logic              ingrid, center;
	logic [QPTR_W-1:0] pool_ptr;

	assign max_sq   = DIST_W'({5'd0, max_q} * {5'd0, max_q});
	assign pool_ptr = pool_q[QPTR_W-1:0];

	// neighbour offset, in-grid test and squared distance to the source point
	always_comb begin
		nxw    = {2'b0, cel_q[14:10]} + {5'b0, ox_q};
		nyw    = {2'b0, cel_q[9:5]}   + {5'b0, oy_q};
		nzw    = {2'b0, cel_q[4:0]}   + {5'b0, oz_q};
		nx     = nxw - 7'd1;
		ny     = nyw - 7'd1;
		nz     = nzw - 7'd1;
		ingrid = (nxw != 7'd0) && (nxw <= 7'd32) && (nyw != 7'd0) && (nyw <= 7'd32)
			&& (nzw != 7'd0) && (nzw <= 7'd32);
		center = (ox_q == 2'd1) && (oy_q == 2'd1) && (oz_q == 2'd1);
		ex     = $signed(nx) - $signed({2'b0, np_q[14:10]});
		ey     = $signed(ny) - $signed({2'b0, np_q[9:5]});
		ez     = $signed(nz) - $signed({2'b0, np_q[4:0]});
		sqx    = ex * ex;
		sqy    = ey * ey;
		sqz    = ez * ez;
		dsum   = DSUM_W'(sqx) + DSUM_W'(sqy) + DSUM_W'(sqz);
	end

	always_comb begin
		sts.sw_last   = (sw_q == CELL_W'(GRID_CELLS - 1));
		sts.blive     = bkt_rd.live;
		sts.nb_end    = (ox_q == 2'd3);
		sts.nb_ok     = ingrid && !center && (dsum <= {2'b0, max_sq});
		sts.better    = (d_q < {2'b0, dist_rd});
		sts.want_push = (d_q[DIST_W-1:0] >= b_q);
		sts.cell_last = (cur_q == bt_q);
		sts.b_last    = (b_q == max_sq);
		sts.pool_full = (pool_q == POOL_W'(QUEUE_ENTRIES));
		sts.push_cur  = cmd.in_prop && (pb_q == b_q);
	end

	// memory port steering
	always_comb begin
		dist_we  = 1'b0; dist_wa = sw_q; dist_wd = max_sq;
		near_we  = 1'b0; near_wa = sw_q; near_wd = '0;
		dist_re  = 1'b0; dist_ra = in_cell_q;
		near_re  = 1'b0; near_ra = in_cell_q;
		qent_we  = 1'b0; qent_wa = pool_ptr; qent_wd = pc_q;
		qent_re  = 1'b0; qent_ra = bkt_rd.head;
		qnext_we = 1'b0; qnext_wa = bt_q; qnext_wd = pool_ptr;
		qnext_re = 1'b0; qnext_ra = cur_q;
		bkt_we   = 1'b0; bkt_wa = sw_q[BKT_W-1:0]; bkt_wd = '0;
		bkt_re   = 1'b0; bkt_ra = b_q;
		case (cmd.op)
			OP_SWEEP: begin
				dist_we = 1'b1;
				near_we = 1'b1;
				bkt_we  = (sw_q < CELL_W'(BUCKETS));
			end
			OP_ADD: begin
				dist_we = 1'b1; dist_wa = in_cell_q; dist_wd = '0;
				near_we = 1'b1; near_wa = in_cell_q; near_wd = in_cell_q;
			end
			OP_PUSH_RD: begin
				if (!sts.pool_full) begin
					qent_we = 1'b1;
					if (sts.push_cur) begin
						qnext_we = 1'b1;
					end else begin
						bkt_re = 1'b1;
						bkt_ra = pb_q;
					end
				end
			end
			OP_PUSH_WR: begin
				bkt_we = 1'b1;
				bkt_wa = pb_q;
				if (bkt_rd.live) begin
					qnext_we = 1'b1;
					qnext_wa = bkt_rd.tail;
					bkt_wd   = '{live: 1'b1, head: bkt_rd.head, tail: pool_ptr};
				end else begin
					bkt_wd = '{live: 1'b1, head: pool_ptr, tail: pool_ptr};
				end
			end
			OP_QRD: begin
				dist_re = 1'b1;
				near_re = 1'b1;
			end
			OP_BRD:  bkt_re = 1'b1;
			OP_BCHK: qent_re = bkt_rd.live;
			OP_CRD: begin
				near_re = 1'b1;
				near_ra = qent_rd;
			end
			OP_NB: begin
				dist_re = sts.nb_ok && !sts.nb_end;
				dist_ra = {nx[4:0], ny[4:0], nz[4:0]};
			end
			OP_NCMP: begin
				if (sts.better) begin
					dist_we = 1'b1; dist_wa = n_q; dist_wd = d_q[DIST_W-1:0];
					near_we = 1'b1; near_wa = n_q; near_wd = np_q;
				end
			end
			OP_CEND: begin
				if (sts.cell_last) begin
					// bucket done: drop it
					bkt_we = 1'b1;
					bkt_wa = b_q;
				end else begin
					qnext_re = 1'b1;
				end
			end
			OP_QNLAT: begin
				qent_re = 1'b1;
				qent_ra = qnext_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (dist_re) dist_rd <= dist_mem[dist_ra];
	end

	always_ff @(posedge clk) begin
		if (near_we) near_mem[near_wa] <= near_wd;
		if (near_re) near_rd <= near_mem[near_ra];
	end

	always_ff @(posedge clk) begin
		if (qent_we) qent_mem[qent_wa] <= qent_wd;
		if (qent_re) qent_rd <= qent_mem[qent_ra];
	end

	always_ff @(posedge clk) begin
		if (qnext_we) qnext_mem[qnext_wa] <= qnext_wd;
		if (qnext_re) qnext_rd <= qnext_mem[qnext_ra];
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
		if (bkt_re) bkt_rd <= bkt_mem[bkt_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= AXIS_W'(MAX_DIST_LIMIT);
			sw_q   <= '0;
			pool_q <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT);
			if (cfg_we) max_q <= (cfg_wdata == '0) ? AXIS_W'(1) : cfg_wdata;
			case (cmd.op)
				OP_LOAD: sw_q <= '0;
				OP_SWEEP: begin
					sw_q   <= sw_q + 1'b1;
					pool_q <= '0;
					ovf_q  <= 1'b0;
				end
				OP_PUSH_RD: begin
					if (sts.pool_full) ovf_q <= 1'b1;
					else if (sts.push_cur) pool_q <= pool_q + 1'b1;
				end
				OP_PUSH_WR: pool_q <= pool_q + 1'b1;
				OP_BNEXT: if (sts.b_last) pool_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				act_q     <= action;
				in_cell_q <= {cell_x, cell_y, cell_z};
				b_q       <= '0;
			end
			OP_ADD: begin
				pb_q <= '0;
				pc_q <= in_cell_q;
			end
			OP_PUSH_RD: if (!sts.pool_full && sts.push_cur) bt_q <= pool_ptr;
			OP_BCHK: begin
				bt_q  <= bkt_rd.tail;
				cur_q <= bkt_rd.head;
			end
			OP_CRD:  cel_q <= qent_rd;
			OP_NLAT: begin
				np_q <= near_rd;
				ox_q <= 2'd0;
				oy_q <= 2'd0;
				oz_q <= 2'd0;
			end
			OP_NB: begin
				n_q <= {nx[4:0], ny[4:0], nz[4:0]};
				d_q <= dsum;
				// advance z fastest, then y, then x; x of three marks the end
				if (oz_q == 2'd2) begin
					oz_q <= 2'd0;
					if (oy_q == 2'd2) begin
						oy_q <= 2'd0;
						ox_q <= ox_q + 2'd1;
					end else begin
						oy_q <= oy_q + 2'd1;
					end
				end else begin
					oz_q <= oz_q + 2'd1;
				end
			end
			OP_NCMP: begin
				pb_q <= d_q[DIST_W-1:0];
				pc_q <= n_q;
			end
			OP_QNLAT: cur_q <= qnext_rd;
			OP_BNEXT: if (!sts.b_last) b_q <= b_q + 1'b1;
			OP_OUT: begin
				if (act_t'(act_q) == ACT_QUERY) begin
					dist_out_q <= dist_rd;
					near_out_q <= near_rd;
				end else begin
					dist_out_q <= '0;
					near_out_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign distance_sq = dist_out_q;
	assign nearest_x   = near_out_q[14:10];
	assign nearest_y   = near_out_q[9:5];
	assign nearest_z   = near_out_q[4:0];
	assign status      = ovf_q;

endmodule

// ===== tb/voxel_field_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_field_checker
// Watches the command, config and result channels of the distance block,
// keeps its own copy of the distance field and bucket queue, predicts the
// word for each accepted command and compares it with the one the block
// shows on done.
// ---------------------------------------------------------------------------
module voxel_field_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [1:0]                  action,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_x,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_y,
	input  logic [vdp_pkg::AXIS_W-1:0]  cell_z,
	input  logic                        cfg_we,
	input  logic [vdp_pkg::AXIS_W-1:0]  cfg_wdata,
	input  logic                        done,
	input  logic [vdp_pkg::DIST_W-1:0]  distance_sq,
	input  logic [vdp_pkg::AXIS_W-1:0]  nearest_x,
	input  logic [vdp_pkg::AXIS_W-1:0]  nearest_y,
	input  logic [vdp_pkg::AXIS_W-1:0]  nearest_z,
	input  logic                        status,
	output int                          errors,
	output int                          outstanding
);
	import vdp_pkg::*;

	typedef struct packed {
		logic [DIST_W-1:0] dsq;
		logic [AXIS_W-1:0] nx;
		logic [AXIS_W-1:0] ny;
		logic [AXIS_W-1:0] nz;
		logic              st;
	} field_word_t;

	bit [DIST_W-1:0] dist_map [GRID_CELLS];
	bit [CELL_W-1:0] near_map [GRID_CELLS];
	bit [CELL_W-1:0] pool_cell [QUEUE_ENTRIES];
	int              pool_link [QUEUE_ENTRIES];
	int              bkt_head [BUCKETS];
	int              bkt_tail [BUCKETS];
	bit              bkt_live [BUCKETS];
	int              pool_used;
	bit              overflow;
	int              reach;
	field_word_t     expected_words [$];

	function automatic int reach_sq();
		return reach * reach;
	endfunction

	function automatic void empty_buckets();
		for (int i = 0; i < BUCKETS; i++) bkt_live[i] = 0;
		pool_used = 0;
	endfunction

	function automatic void enqueue(int bkt, int cell_idx);
		int e;
		if (bkt >= BUCKETS) return;
		if (pool_used >= QUEUE_ENTRIES) begin
			overflow = 1;
			return;
		end
		e = pool_used;
		pool_used++;
		pool_cell[e] = cell_idx[CELL_W-1:0];
		if (bkt_live[bkt]) begin
			pool_link[bkt_tail[bkt]] = e;
		end else begin
			bkt_head[bkt] = e;
			bkt_live[bkt] = 1;
		end
		bkt_tail[bkt] = e;
	endfunction

	function automatic void wipe_field();
		int m;
		m = reach_sq();
		for (int i = 0; i < GRID_CELLS; i++) begin
			dist_map[i] = m[DIST_W-1:0];
			near_map[i] = '0;
		end
		empty_buckets();
		overflow = 0;
	endfunction

	// offer every in-grid neighbour within the limit the distance to this cell's nearest point
	function automatic void relax_around(int cell_idx, int bkt, int msq);
		int x, y, z, px, py, pz, nx, ny, nz, d, n;
		bit [CELL_W-1:0] np;
		x  = (cell_idx >> 10) & 31;
		y  = (cell_idx >> 5) & 31;
		z  = cell_idx & 31;
		np = near_map[cell_idx];
		px = np[14:10];
		py = np[9:5];
		pz = np[4:0];
		for (int dx = -1; dx <= 1; dx++) begin
			nx = x + dx;
			if (nx < 0 || nx >= CELLS_PER_AXIS) continue;
			for (int dy = -1; dy <= 1; dy++) begin
				ny = y + dy;
				if (ny < 0 || ny >= CELLS_PER_AXIS) continue;
				for (int dz = -1; dz <= 1; dz++) begin
					nz = z + dz;
					if (nz < 0 || nz >= CELLS_PER_AXIS) continue;
					if (dx == 0 && dy == 0 && dz == 0) continue;
					d = (nx - px) * (nx - px) + (ny - py) * (ny - py) + (nz - pz) * (nz - pz);
					if (d > msq) continue;
					n = (nx * CELLS_PER_AXIS + ny) * CELLS_PER_AXIS + nz;
					if (d < dist_map[n]) begin
						dist_map[n] = d[DIST_W-1:0];
						near_map[n] = np;
						if (d >= bkt) enqueue(d, n);
					end
				end
			end
		end
	endfunction

	function automatic void sweep_buckets();
		int msq, cur;
		msq = reach_sq();
		for (int b = 0; b <= msq && b < BUCKETS; b++) begin
			if (!bkt_live[b]) continue;
			cur = bkt_head[b];
			forever begin
				relax_around(pool_cell[cur], b, msq);
				if (cur == bkt_tail[b]) break;
				cur = pool_link[cur];
			end
		end
		empty_buckets();
	endfunction

	function automatic field_word_t predict_word(act_t act, int x, int y, int z);
		field_word_t w;
		int c;
		w = '0;
		c = (x * CELLS_PER_AXIS + y) * CELLS_PER_AXIS + z;
		case (act)
			ACT_ADD: begin
				dist_map[c] = '0;
				near_map[c] = c[CELL_W-1:0];
				enqueue(0, c);
			end
			ACT_PROP: sweep_buckets();
			ACT_QUERY: begin
				w.dsq = dist_map[c];
				w.nx  = near_map[c][14:10];
				w.ny  = near_map[c][9:5];
				w.nz  = near_map[c][4:0];
			end
			default: wipe_field();
		endcase
		w.st = overflow;
		return w;
	endfunction

	function automatic void note_failure(string msg);
		errors++;
		if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_word_t got, want, next_w;
		if (!arst_n) begin
			reach       = MAX_DIST_LIMIT;
			wipe_field();
			errors      = 0;
			outstanding = 0;
			expected_words.delete();
		end else begin
			if (done) begin
				got = {distance_sq, nearest_x, nearest_y, nearest_z, status};
				if (expected_words.size() == 0) begin
					note_failure("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					if (got.dsq !== want.dsq)
						note_failure($sformatf("distance_sq exp %0d got %0d", want.dsq, got.dsq));
					if (got.nx !== want.nx)
						note_failure($sformatf("nearest_x exp %0d got %0d", want.nx, got.nx));
					if (got.ny !== want.ny)
						note_failure($sformatf("nearest_y exp %0d got %0d", want.ny, got.ny));
					if (got.nz !== want.nz)
						note_failure($sformatf("nearest_z exp %0d got %0d", want.nz, got.nz));
					if (got.st !== want.st)
						note_failure($sformatf("status exp %0d got %0d", want.st, got.st));
				end
			end
			if (start && !busy) begin
				next_w = predict_word(act_t'(action), cell_x, cell_y, cell_z);
				expected_words = {expected_words, next_w};
			end
			if (cfg_we) begin
				reach = cfg_wdata;
				if (reach == 0) reach = 1;
				if (reach > MAX_DIST_LIMIT) reach = MAX_DIST_LIMIT;
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Command stimulus for the voxel distance block: directed adds, sweeps,
// queries and clears at several propagation limits, then random traffic
// with sender gaps; the checker beside the block predicts every word.
// ---------------------------------------------------------------------------
module tb_top;
	import vdp_pkg::*;

	localparam int CYCLE_LIMIT = 8000000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        action;
	logic [AXIS_W-1:0] cell_x, cell_y, cell_z;
	logic              cfg_we;
	logic [AXIS_W-1:0] cfg_wdata;
	logic              done;
	logic [DIST_W-1:0] distance_sq;
	logic [AXIS_W-1:0] nearest_x, nearest_y, nearest_z;
	logic              status;
	int                errors;
	int                outstanding;
	int                cycles = 0;
	int                idle_pct;
	int                last_x, last_y, last_z;

	voxel_distance_propagation_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.distance_sq(distance_sq), .nearest_x(nearest_x), .nearest_y(nearest_y),
		.nearest_z(nearest_z), .status(status)
	);

	voxel_field_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.distance_sq(distance_sq), .nearest_x(nearest_x), .nearest_y(nearest_y),
		.nearest_z(nearest_z), .status(status),
		.errors(errors), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// hold the word until the block takes it, then maybe drop start for a gap
	task automatic send_word(act_t act, int x, int y, int z);
		start  <= 1'b1;
		action <= act;
		cell_x <= x[AXIS_W-1:0];
		cell_y <= y[AXIS_W-1:0];
		cell_z <= z[AXIS_W-1:0];
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reach(int v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[AXIS_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int r, x, y, z;
		r = $urandom_range(0, 999);
		x = $urandom_range(0, 31);
		y = $urandom_range(0, 31);
		z = $urandom_range(0, 31);
		if (r < 5) begin
			send_word(ACT_CLEAR, x, y, z);
		end else if (r < 60) begin
			send_word(ACT_PROP, x, y, z);
		end else if (r < 530) begin
			last_x = x;
			last_y = y;
			last_z = z;
			send_word(ACT_ADD, x, y, z);
		end else begin
			// aim about half the queries at the neighborhood of the latest obstacle
			if ($urandom_range(0, 1)) begin
				x = last_x + $urandom_range(0, 6) - 3;
				y = last_y + $urandom_range(0, 6) - 3;
				z = last_z + $urandom_range(0, 6) - 3;
				x = (x < 0) ? 0 : (x > 31) ? 31 : x;
				y = (y < 0) ? 0 : (y > 31) ? 31 : y;
				z = (z < 0) ? 0 : (z > 31) ? 31 : z;
			end
			send_word(ACT_QUERY, x, y, z);
		end
	endtask

	initial begin
		int reach_list [4];
		int pct_list [4];
		idle_pct  = 0;
		last_x    = 0;
		last_y    = 0;
		last_z    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		action    = ACT_ADD;
		cell_x    = '0;
		cell_y    = '0;
		cell_z    = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		reach_list = '{2, 1, 0, 2};
		pct_list   = '{0, 49, 0, 33};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the field sweep after reset
		do @(posedge clk); while (busy);

		write_reach(2);
		send_word(ACT_CLEAR, 0, 0, 0);
		send_word(ACT_QUERY, 5, 5, 5);
		send_word(ACT_ADD, 0, 0, 0);
		send_word(ACT_ADD, 31, 31, 31);
		send_word(ACT_ADD, 31, 0, 17);
		send_word(ACT_ADD, 0, 0, 0);
		send_word(ACT_PROP, 0, 0, 0);
		send_word(ACT_QUERY, 0, 0, 0);
		send_word(ACT_QUERY, 1, 0, 0);
		send_word(ACT_QUERY, 1, 1, 1);
		send_word(ACT_QUERY, 2, 0, 0);
		send_word(ACT_QUERY, 30, 30, 30);
		send_word(ACT_QUERY, 31, 2, 17);
		send_word(ACT_QUERY, 15, 15, 15);
		send_word(ACT_PROP, 31, 31, 31);

		// widest limit: one obstacle floods the grid and overflows the pool
		write_reach(31);
		send_word(ACT_ADD, 16, 16, 16);
		send_word(ACT_PROP, 0, 0, 0);
		send_word(ACT_QUERY, 16, 16, 16);
		send_word(ACT_QUERY, 0, 31, 0);
		send_word(ACT_QUERY, 20, 10, 16);
		send_word(ACT_CLEAR, 31, 31, 31);
		send_word(ACT_QUERY, 20, 10, 16);

		// zero acts as the narrowest limit
		write_reach(0);
		send_word(ACT_ADD, 10, 21, 5);
		send_word(ACT_PROP, 0, 0, 0);
		send_word(ACT_QUERY, 11, 21, 5);
		send_word(ACT_QUERY, 11, 22, 5);

		for (int ph = 0; ph < 4; ph++) begin
			write_reach(reach_list[ph]);
			idle_pct = pct_list[ph];
			for (int i = 0; i < 212; i++) random_word();
		end
		idle_pct = 0;
		drain();

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
